>>> src/tpm_pkg.sv
// tpm_pkg: item, configuration and pipeline types, constants and helpers
// for the torque plausibility monitor; no dependencies
package tpm_pkg;

    localparam int unsigned TimerW = 32;
    localparam int unsigned DtW    = 16;
    localparam int unsigned PctW   = 10;
    localparam int unsigned NmW    = 14;
    localparam int unsigned RpmW   = 14;
    localparam int unsigned KpaW   = 10;
    localparam int unsigned PermW  = 15;
    localparam int unsigned ProdW  = PctW + NmW;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [TimerW-1:0] TIMER_MAX = '1;
    localparam logic [PctW-1:0]   PEDAL_FULL = 10'd1000;
    localparam logic [RpmW-1:0]   IDLE_RPM = 14'd1500;
    localparam logic [PermW-1:0]  IDLE_LOW_ALLOW = 15'd400;
    localparam logic [PermW-1:0]  IDLE_HIGH_ALLOW = 15'd150;
    localparam logic [RpmW:0]     OVERSPEED_MARGIN = 15'd500;
    localparam logic [NmW-1:0]    IDLE_CAP = 14'd300;

    // divide by 1000 as shift by 3 then multiply by ceil(2^28 / 125)
    localparam int unsigned       RecipShift = 28;
    localparam int unsigned       RecipW = 22;
    localparam logic [RecipW-1:0] RECIP_125 = 22'd2147484;

    localparam logic [CfgIdxW-1:0] REG_PEDAL_LIMIT    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_THROTTLE_LIMIT = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_TRACKING_LIMIT = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_DEBOUNCE       = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TORQUE_DEBOUNCE = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_TORQUE_MARGIN  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT    = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_OVERBOOST      = 3'd7;

    localparam logic [2:0] FAULT_NONE      = 3'd0;
    localparam logic [2:0] FAULT_PEDAL     = 3'd1;
    localparam logic [2:0] FAULT_TPS       = 3'd2;
    localparam logic [2:0] FAULT_TRACKING  = 3'd3;
    localparam logic [2:0] FAULT_TORQUE    = 3'd4;
    localparam logic [2:0] FAULT_OVERSPEED = 3'd5;
    localparam logic [2:0] FAULT_OVERBOOST = 3'd6;

    localparam logic [1:0] LIMP_OK       = 2'd0;
    localparam logic [1:0] LIMP_REDUCED  = 2'd1;
    localparam logic [1:0] LIMP_IDLE     = 2'd2;
    localparam logic [1:0] LIMP_SHUTDOWN = 2'd3;

    typedef struct packed {
        logic [PctW-1:0] pedal_first;
        logic [PctW-1:0] pedal_second;
        logic [PctW-1:0] throttle_first;
        logic [PctW-1:0] throttle_second;
        logic [PctW-1:0] throttle_command;
        logic [DtW-1:0]  elapsed_time;
        logic [RpmW-1:0] engine_speed;
        logic [NmW-1:0]  peak_torque;
        logic [NmW-1:0]  actual_torque;
        logic [KpaW-1:0] manifold_pressure;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       limp_level;
        logic [2:0]       root_fault;
        logic [5:0]       fault_history;
        logic [PermW-1:0] allowed_torque;
        logic [NmW-1:0]   torque_cap;
    } out_item_t;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic [31:0]        value;
    } cfg_wr_t;

    typedef struct packed {
        logic [PctW-1:0]   pedal_disagree_limit;
        logic [PctW-1:0]   throttle_disagree_limit;
        logic [PctW-1:0]   tracking_limit;
        logic [TimerW-1:0] debounce_time;
        logic [TimerW-1:0] torque_debounce_time;
        logic [NmW-1:0]    torque_margin;
        logic [RpmW-1:0]   speed_limit;
        logic [KpaW-1:0]   overboost_limit;
    } cfg_t;

    // first stage to second stage
    typedef struct packed {
        logic             pedal_fault;
        logic             throttle_fault;
        logic             tracking_fault;
        logic             overspeed;
        logic             overboost;
        logic             low_idle;
        logic [ProdW-1:0] product;
        logic [DtW-1:0]   elapsed_time;
        logic [NmW-1:0]   peak_torque;
        logic [NmW-1:0]   actual_torque;
    } mid_t;

    function automatic logic [PctW-1:0] abs_diff(logic [PctW-1:0] a, logic [PctW-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [TimerW-1:0] timer_step(logic [TimerW-1:0] t, logic active,
                                                     logic [DtW-1:0] dt);
        logic [TimerW:0] sum;
        sum = {1'b0, t} + {{(TimerW + 1 - DtW){1'b0}}, dt};
        if (!active)
        begin
            return '0;
        end
        return sum[TimerW] ? TIMER_MAX : sum[TimerW-1:0];
    endfunction

endpackage

>>> src/tpm_stream_if.sv
// tpm_stream_if: valid/ready channel carrying one item of a given type
// depends on nothing; payload type set per instance
interface tpm_stream_if #(parameter type item_t = logic) ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/torque_plausibility_monitor_core.sv
// torque_plausibility_monitor_core: top level, handshake control around two stages
// depends on tpm_pkg, tpm_stream_if, tpm_cfg_regs, tpm_sense, tpm_judge
//
// One monitor sample in, one result out. The block takes a sample every cycle while
// sample.ready is high; an accepted sample is held in the first stage register, then
// in the output register, from which the sink takes it: the first stage updates the
// three sensor timers and forms the pedal x max torque product, the second divides by
// 1000, runs the torque timer and latches fault, history and limp level. Each
// stage keeps its own state, so items stream without gaps; the output register
// holds a result while the sink stalls and the first stage keeps accepting until
// both registers are full. Configuration writes are taken at any cycle and should
// be made only while no sample is in flight.
module torque_plausibility_monitor_core import tpm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tpm_stream_if.sink   sample,
    tpm_stream_if.source result,
    tpm_stream_if.sink   cfg
);

    cfg_t      regs;
    mid_t      mid;
    out_item_t res;
    logic      accept;
    logic      advance;
    logic      mid_valid_reg, mid_valid_next;
    logic      out_valid_reg, out_valid_next;

    assign advance      = mid_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !mid_valid_reg || advance;
    assign accept       = sample.valid && sample.ready;

    always_comb
    begin
        mid_valid_next = mid_valid_reg;
        if (accept)
        begin
            mid_valid_next = 1'b1;
        end
        else if (advance)
        begin
            mid_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    tpm_cfg_regs u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    tpm_sense u_sense
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .regs   (regs),
        .accept (accept),
        .item   (sample.data),
        .mid    (mid)
    );

    tpm_judge u_judge
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .regs    (regs),
        .advance (advance),
        .mid     (mid),
        .res     (res)
    );

    assign result.valid = out_valid_reg;
    assign result.data  = res;

endmodule

>>> src/tpm_cfg_regs.sv
// tpm_cfg_regs: configuration register file written over the cfg channel
// depends on tpm_pkg and tpm_stream_if
module tpm_cfg_regs import tpm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tpm_stream_if.sink   cfg,
    output cfg_t         regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.data.index)
                REG_PEDAL_LIMIT:     regs_next.pedal_disagree_limit = cfg.data.value[PctW-1:0];
                REG_THROTTLE_LIMIT:  regs_next.throttle_disagree_limit = cfg.data.value[PctW-1:0];
                REG_TRACKING_LIMIT:  regs_next.tracking_limit = cfg.data.value[PctW-1:0];
                REG_DEBOUNCE:        regs_next.debounce_time = cfg.data.value;
                REG_TORQUE_DEBOUNCE: regs_next.torque_debounce_time = cfg.data.value;
                REG_TORQUE_MARGIN:   regs_next.torque_margin = cfg.data.value[NmW-1:0];
                REG_SPEED_LIMIT:     regs_next.speed_limit = cfg.data.value[RpmW-1:0];
                REG_OVERBOOST:       regs_next.overboost_limit = cfg.data.value[KpaW-1:0];
                default:             regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.pedal_disagree_limit    <= 10'd50;
            regs_reg.throttle_disagree_limit <= 10'd50;
            regs_reg.tracking_limit          <= 10'd100;
            regs_reg.debounce_time           <= 32'd100000;
            regs_reg.torque_debounce_time    <= 32'd200000;
            regs_reg.torque_margin           <= 14'd200;
            regs_reg.speed_limit             <= 14'd6500;
            regs_reg.overboost_limit         <= 10'd250;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

>>> src/tpm_sense.sv
// tpm_sense: first stage; disagreement timers, pedal selection, pedal x max product
// depends on tpm_pkg
module tpm_sense import tpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     regs,
    input  logic     accept,
    input  in_item_t item,
    output mid_t     mid
);

    logic [TimerW-1:0] pedal_timer_reg, pedal_timer_next;
    logic [TimerW-1:0] throttle_timer_reg, throttle_timer_next;
    logic [TimerW-1:0] tracking_timer_reg, tracking_timer_next;
    mid_t              mid_reg, mid_next;
    logic [PctW-1:0]   pedal;

    always_comb
    begin
        pedal_timer_next = timer_step(pedal_timer_reg,
            abs_diff(item.pedal_first, item.pedal_second) > regs.pedal_disagree_limit,
            item.elapsed_time);
        throttle_timer_next = timer_step(throttle_timer_reg,
            abs_diff(item.throttle_first, item.throttle_second) > regs.throttle_disagree_limit,
            item.elapsed_time);
        tracking_timer_next = timer_step(tracking_timer_reg,
            abs_diff(item.throttle_command, item.throttle_first) > regs.tracking_limit,
            item.elapsed_time);

        mid_next.pedal_fault    = pedal_timer_next > regs.debounce_time;
        mid_next.throttle_fault = throttle_timer_next > regs.debounce_time;
        mid_next.tracking_fault = tracking_timer_next > regs.debounce_time;
        mid_next.overspeed      = {1'b0, item.engine_speed}
                                  > ({1'b0, regs.speed_limit} + OVERSPEED_MARGIN);
        mid_next.overboost      = item.manifold_pressure > regs.overboost_limit;
        mid_next.low_idle       = item.engine_speed < IDLE_RPM;

        // lower track once the pedal fault is confirmed
        pedal = item.pedal_first;
        if (mid_next.pedal_fault && (item.pedal_second < item.pedal_first))
        begin
            pedal = item.pedal_second;
        end
        if (pedal > PEDAL_FULL)
        begin
            pedal = PEDAL_FULL;
        end

        mid_next.product       = {{NmW{1'b0}}, pedal} * {{PctW{1'b0}}, item.peak_torque};
        mid_next.elapsed_time  = item.elapsed_time;
        mid_next.peak_torque   = item.peak_torque;
        mid_next.actual_torque = item.actual_torque;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pedal_timer_reg    <= '0;
            throttle_timer_reg <= '0;
            tracking_timer_reg <= '0;
        end
        else if (accept)
        begin
            pedal_timer_reg    <= pedal_timer_next;
            throttle_timer_reg <= throttle_timer_next;
            tracking_timer_reg <= tracking_timer_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

>>> src/tpm_judge.sv
// tpm_judge: second stage; permissible torque, torque timer, fault latching, torque cap
// depends on tpm_pkg
module tpm_judge import tpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      regs,
    input  logic      advance,
    input  mid_t      mid,
    output out_item_t res
);

    localparam int unsigned QuotW = ProdW - 3;

    logic [TimerW-1:0]           torque_timer_reg, torque_timer_next;
    logic [1:0]                  limp_reg, limp_next;
    logic [2:0]                  first_reg, first_next;
    logic [5:0]                  seen_reg, seen_next;
    out_item_t                   res_reg, res_next;
    logic [QuotW+RecipW-1:0]     recip_prod;
    logic [NmW-1:0]              quot;
    logic [PermW-1:0]            perm;
    logic                        torque_over;
    logic [2:0]                  fault;
    logic [1:0]                  limp;
    logic [NmW-1:0]              cap;

    always_comb
    begin
        recip_prod = {{RecipW{1'b0}}, mid.product[ProdW-1:3]}
                     * {{QuotW{1'b0}}, RECIP_125};
        quot = recip_prod[RecipShift+NmW-1:RecipShift];
        perm = {1'b0, quot} + (mid.low_idle ? IDLE_LOW_ALLOW : IDLE_HIGH_ALLOW);
        torque_over = {2'b00, mid.actual_torque}
                      > ({1'b0, perm} + {2'b00, regs.torque_margin});
        torque_timer_next = timer_step(torque_timer_reg, torque_over, mid.elapsed_time);

        // later checks override earlier ones
        fault = FAULT_NONE;
        limp  = LIMP_OK;
        if (mid.pedal_fault)
        begin
            fault = FAULT_PEDAL;
            limp  = LIMP_REDUCED;
        end
        if (mid.throttle_fault)
        begin
            fault = FAULT_TPS;
            limp  = LIMP_IDLE;
        end
        if (mid.tracking_fault)
        begin
            fault = FAULT_TRACKING;
            limp  = LIMP_IDLE;
        end
        if (torque_timer_next > regs.torque_debounce_time)
        begin
            fault = FAULT_TORQUE;
            limp  = LIMP_IDLE;
        end
        if (mid.overspeed)
        begin
            fault = FAULT_OVERSPEED;
            limp  = LIMP_SHUTDOWN;
        end
        if (mid.overboost)
        begin
            fault = FAULT_OVERBOOST;
            limp  = LIMP_SHUTDOWN;
        end

        seen_next  = seen_reg;
        first_next = first_reg;
        if (fault != FAULT_NONE)
        begin
            seen_next = seen_reg | (6'd1 << (fault - 3'd1));
            if (first_reg == FAULT_NONE)
            begin
                first_next = fault;
            end
        end
        limp_next = (limp > limp_reg) ? limp : limp_reg;

        case (limp_next)
            LIMP_OK:      cap = mid.peak_torque;
            LIMP_REDUCED: cap = mid.peak_torque >> 1;
            LIMP_IDLE:    cap = IDLE_CAP;
            default:      cap = '0;
        endcase

        res_next.limp_level     = limp_next;
        res_next.root_fault     = first_next;
        res_next.fault_history  = seen_next;
        res_next.allowed_torque = perm;
        res_next.torque_cap     = cap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            torque_timer_reg <= '0;
            limp_reg         <= LIMP_OK;
            first_reg        <= FAULT_NONE;
            seen_reg         <= '0;
        end
        else if (advance)
        begin
            torque_timer_reg <= torque_timer_next;
            limp_reg         <= limp_next;
            first_reg        <= first_next;
            seen_reg         <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

    a_limp_rises : assert property (@(posedge clk) disable iff (!rst_n)
        limp_reg >= $past(limp_reg))
        else $error("limp level dropped");

    a_root_kept : assert property (@(posedge clk) disable iff (!rst_n)
        first_reg != FAULT_NONE |=> $stable(first_reg))
        else $error("root fault changed after latching");

    a_root_in_history : assert property (@(posedge clk) disable iff (!rst_n)
        first_reg != FAULT_NONE |-> seen_reg[first_reg - 3'd1])
        else $error("root fault missing from history");

    a_history_kept : assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg & $past(seen_reg)) == $past(seen_reg))
        else $error("fault history bit cleared");

endmodule
